[design/trailing_window_average_filter_unit_macros.svh]
// Assertion macros for the trailing window average filter.
// Taken in by the checker file only; needs nothing else.
`ifndef TRAILING_WINDOW_AVERAGE_FILTER_UNIT_MACROS_SVH
`define TRAILING_WINDOW_AVERAGE_FILTER_UNIT_MACROS_SVH

// clocked property, ignored while reset is asserted
`define TWAF_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked property, also checked during reset
`define TWAF_ASSERT_RST(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/twaf_pkg.sv]
// Shared types and constants of the trailing window average filter.
// No dependencies; used by every other file of the block but the macro header.
package twaf_pkg;

	localparam int SAMPLE_W  = 32;
	localparam int DEPTH_W   = 4;
	// up to 15 samples of 32 bits
	localparam int SUM_W     = 36;
	localparam int DIV_CNT_W = 6;

	localparam logic [DEPTH_W-1:0] MIN_DEPTH   = 4'd3;
	localparam logic [DEPTH_W-1:0] DEPTH_RESET = 4'd10;

	typedef struct packed {
		logic start;
		logic sum_en;
		logic div_load;
		logic div_step;
		logic finish;
	} twaf_cmd_t;

	typedef struct packed {
		logic sum_done;
		logic div_done;
	} twaf_sts_t;

endpackage

[design/twaf_if.sv]
// Channel interfaces of the trailing window average filter: samples in,
// averages out and the depth register write. Depends on twaf_pkg.
interface twaf_in_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [twaf_pkg::SAMPLE_W-1:0] sample;
	logic                                 first_of_series;

	modport source (output valid, output sample, output first_of_series, input ready);
	modport sink (input valid, input sample, input first_of_series, output ready);
endinterface

interface twaf_out_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [twaf_pkg::SAMPLE_W-1:0] average;
	logic                                 depth_ok;

	modport source (output valid, output average, output depth_ok, input ready);
	modport sink (input valid, input average, input depth_ok, output ready);
endinterface

interface twaf_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [twaf_pkg::DEPTH_W-1:0]     window_depth;

	modport source (output valid, output window_depth, input ready);
	modport sink (input valid, input window_depth, output ready);
endinterface

[design/twaf_datapath.sv]
// Datapath of the trailing window average filter: history ring memory,
// window accumulator, bit-serial divider and result registers. Uses twaf_pkg.
module twaf_datapath #(
	parameter int MAX_WINDOW = 10
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  twaf_pkg::twaf_cmd_t                  cmd,
	output twaf_pkg::twaf_sts_t                  sts,
	input  logic                                 cfg_we,
	input  logic [twaf_pkg::DEPTH_W-1:0]         cfg_depth,
	input  logic signed [twaf_pkg::SAMPLE_W-1:0] in_sample,
	input  logic                                 in_first,
	output logic signed [twaf_pkg::SAMPLE_W-1:0] average,
	output logic                                 depth_ok
);
	localparam int PW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int FW = $clog2(MAX_WINDOW + 1);
	localparam int DW = twaf_pkg::DEPTH_W;
	localparam int CW = (FW > DW) ? FW : DW;
	localparam int SW = twaf_pkg::SUM_W;
	localparam int XW = twaf_pkg::SAMPLE_W;
	localparam int QW = twaf_pkg::DIV_CNT_W;
	localparam logic [PW-1:0] LAST_SLOT = PW'(MAX_WINDOW - 1);

	logic [XW-1:0] hist_mem [MAX_WINDOW];

	logic [DW-1:0] depth_q;
	logic [FW-1:0] fill_q;
	logic [PW-1:0] wp_q;
	logic [PW-1:0] rd_ptr_q;
	logic [DW-1:0] rem_cnt_q;
	logic          rvalid_s1;
	logic [XW-1:0] rdata_s1;
	logic [XW-1:0] sample_q;
	logic          ok_q;
	logic [SW-1:0] sum_q;
	logic          neg_q;
	logic [SW-1:0] quo_q;
	logic [DW-1:0] rmd_q;
	logic [QW-1:0] div_cnt_q;
	logic [XW-1:0] avg_q;
	logic          dok_q;

	logic          depth_valid;
	logic [FW-1:0] fill_eff;
	logic [PW-1:0] wp_eff;
	logic [PW-1:0] rd_start;
	logic [CW-1:0] fill_cw;
	logic [CW-1:0] depth_cw;
	logic [CW-1:0] n_cw;
	logic [DW-1:0] n_start;
	logic [DW:0]   divisor;
	logic [DW:0]   trial;
	logic [SW-1:0] sum_abs;
	logic [XW-1:0] quo_low;

	assign depth_valid = (depth_q >= twaf_pkg::MIN_DEPTH) && (CW'(depth_q) <= CW'(MAX_WINDOW));
	assign fill_eff    = in_first ? '0 : fill_q;
	assign wp_eff      = in_first ? '0 : wp_q;
	assign rd_start    = (wp_eff == '0) ? LAST_SLOT : wp_eff - PW'(1);
	assign fill_cw     = CW'(fill_eff);
	assign depth_cw    = CW'(depth_q);
	assign n_cw        = (fill_cw < depth_cw) ? fill_cw : depth_cw;
	assign n_start     = depth_valid ? DW'(n_cw) : '0;

	assign divisor = {1'b0, depth_q} + (DW + 1)'(1);
	assign trial   = {rmd_q, quo_q[SW-1]};
	assign sum_abs = sum_q[SW-1] ? -sum_q : sum_q;
	assign quo_low = quo_q[XW-1:0];

	assign sts.sum_done = (rem_cnt_q == '0) && !rvalid_s1;
	assign sts.div_done = (div_cnt_q == '0);

	assign average  = avg_q;
	assign depth_ok = dok_q;

	// history ring, one read port, registered read
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			hist_mem[wp_q] <= sample_q;
		end
		if (cmd.sum_en && rem_cnt_q != '0) begin
			rdata_s1 <= hist_mem[rd_ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q   <= twaf_pkg::DEPTH_RESET;
			fill_q    <= '0;
			wp_q      <= '0;
			rd_ptr_q  <= '0;
			rem_cnt_q <= '0;
			rvalid_s1 <= 1'b0;
			sum_q     <= '0;
			ok_q      <= 1'b0;
			div_cnt_q <= '0;
		end else begin
			if (cfg_we) begin
				depth_q <= cfg_depth;
			end
			if (cmd.start) begin
				fill_q    <= fill_eff;
				wp_q      <= wp_eff;
				rd_ptr_q  <= rd_start;
				rem_cnt_q <= n_start;
				rvalid_s1 <= 1'b0;
				sum_q     <= '0;
				ok_q      <= depth_valid;
			end else if (cmd.sum_en) begin
				if (rem_cnt_q != '0) begin
					rd_ptr_q  <= (rd_ptr_q == '0) ? LAST_SLOT : rd_ptr_q - PW'(1);
					rem_cnt_q <= rem_cnt_q - DW'(1);
				end
				rvalid_s1 <= (rem_cnt_q != '0);
				if (rvalid_s1) begin
					sum_q <= sum_q + {{(SW - XW){rdata_s1[XW-1]}}, rdata_s1};
				end
			end
			if (cmd.div_load) begin
				div_cnt_q <= QW'(SW);
			end else if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q - QW'(1);
			end
			if (cmd.finish) begin
				wp_q <= (wp_q == LAST_SLOT) ? '0 : wp_q + PW'(1);
				if (fill_q != FW'(MAX_WINDOW)) begin
					fill_q <= fill_q + FW'(1);
				end
			end
		end
	end

	// restoring division of the magnitude, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			sample_q <= in_sample;
		end
		if (cmd.div_load) begin
			neg_q <= sum_q[SW-1];
			quo_q <= sum_abs;
			rmd_q <= '0;
		end else if (cmd.div_step) begin
			if (trial >= divisor) begin
				rmd_q <= DW'(trial - divisor);
				quo_q <= {quo_q[SW-2:0], 1'b1};
			end else begin
				rmd_q <= trial[DW-1:0];
				quo_q <= {quo_q[SW-2:0], 1'b0};
			end
		end
		if (cmd.finish) begin
			avg_q <= neg_q ? -quo_low : quo_low;
			dok_q <= ok_q;
		end
	end

endmodule

[design/twaf_ctrl.sv]
// Controller of the trailing window average filter: sequences accumulate,
// divide and result hand-over, and owns the output word valid. Uses twaf_pkg.
module twaf_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  twaf_pkg::twaf_sts_t sts,
	output twaf_pkg::twaf_cmd_t cmd
);
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SUM,
		ST_DIV,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;

	assign in_ready     = (state_q == ST_IDLE);
	assign out_valid    = out_valid_q;
	assign cmd.start    = (state_q == ST_IDLE) && in_valid;
	assign cmd.sum_en   = (state_q == ST_SUM);
	assign cmd.div_load = (state_q == ST_SUM) && sts.sum_done;
	assign cmd.div_step = (state_q == ST_DIV) && !sts.div_done;
	assign cmd.finish   = (state_q == ST_FINISH) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					if (sts.sum_done) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (sts.div_done) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					// waits while the previous word is still held
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[design/trailing_window_average_filter_unit.sv]
// Trailing window average filter: for each sample, returns the sum of up to
// window_depth preceding samples of the series divided by window_depth+1,
// truncated toward zero. Takes one sample at a time: each item sums n held
// samples (the smaller of samples seen in the series and the depth, at most
// MAX_WINDOW), one per cycle through the single read port of the history
// memory, and then runs a bit-serial divider over its 36 quotient bits.
// The finished word sits in an output register, so the next sample is
// taken while it waits downstream.
// A depth outside 3..MAX_WINDOW gives 0 with depth_ok low; the sample still
// enters the history. The depth register resets to 10 and is always ready.
module trailing_window_average_filter_unit #(
	parameter int MAX_WINDOW = 10
) (
	input logic        clk,
	input logic        arst_n,
	twaf_in_if.sink    samples,
	twaf_out_if.source results,
	twaf_cfg_if.sink   cfg
);
	twaf_pkg::twaf_cmd_t cmd;
	twaf_pkg::twaf_sts_t sts;

	assign cfg.ready = 1'b1;

	twaf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (samples.valid),
		.in_ready  (samples.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	twaf_datapath #(
		.MAX_WINDOW (MAX_WINDOW)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_we    (cfg.valid),
		.cfg_depth (cfg.window_depth),
		.in_sample (samples.sample),
		.in_first  (samples.first_of_series),
		.average   (results.average),
		.depth_ok  (results.depth_ok)
	);

endmodule

[design/twaf_checker.sv]
// Port-level checks of the trailing window average filter and their bind.
// Depends on twaf_pkg and the assertion macro header.
`include "trailing_window_average_filter_unit_macros.svh"

module twaf_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 in_valid,
	input logic                                 in_ready,
	input logic                                 out_valid,
	input logic                                 out_ready,
	input logic signed [twaf_pkg::SAMPLE_W-1:0] average,
	input logic                                 depth_ok
);

	`TWAF_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(average) && $stable(depth_ok), "result word changed while stalled")
	`TWAF_ASSERT(a_bad_depth_zero, clk, arst_n, out_valid && !depth_ok |-> average == '0, "non-zero average with bad depth")
	`TWAF_ASSERT(a_one_at_a_time, clk, arst_n, in_valid && in_ready |=> !in_ready, "sample taken while busy")
	`TWAF_ASSERT_RST(a_reset_quiet, clk, !arst_n |-> !out_valid, "result word shown in reset")

endmodule

bind trailing_window_average_filter_unit twaf_checker u_twaf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (samples.valid),
	.in_ready  (samples.ready),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.average   (results.average),
	.depth_ok  (results.depth_ok)
);
